// File: src/aaq_pkg.sv
// Shared types, constants and helpers for the axis-angle to quaternion pipeline.
package aaq_pkg;

	// internal datapath width for the CORDIC x, y and z words
	localparam int CW = 34;
	localparam int TABLE_LEN = 30;

	localparam logic signed [31:0]   ANGLE_LIMIT     = 32'sd1686629713;
	localparam logic signed [CW-1:0] PI_Q30          = 34'sd3373259426;
	localparam logic signed [CW-1:0] PI_HALF_Q30     = 34'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [31:0]   ONE_Q30         = 32'sd1073741824;
	localparam logic signed [63:0]   ROUND_HALF      = 64'sd536870912;

	// one item as it travels through the rotation stages
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
		logic                 zero;
		logic signed [31:0]   ax;
		logic signed [31:0]   ay;
		logic signed [31:0]   az;
	} cordic_t;

	// atan(2^-i) in Q.30, truncated
	function automatic logic [31:0] atan_q30(input int idx);
		logic [31:0] r;
		begin
			case (idx)
				0:  r = 32'h3243F6A8;
				1:  r = 32'h1DAC6705;
				2:  r = 32'h0FADBAFC;
				3:  r = 32'h07F56EA6;
				4:  r = 32'h03FEAB76;
				5:  r = 32'h01FFD55B;
				6:  r = 32'h00FFFAAA;
				7:  r = 32'h007FFF55;
				8:  r = 32'h003FFFEA;
				9:  r = 32'h001FFFFD;
				10: r = 32'h000FFFFF;
				11: r = 32'h0007FFFF;
				12: r = 32'h0003FFFF;
				13: r = 32'h0001FFFF;
				14: r = 32'h0000FFFF;
				15: r = 32'h00007FFF;
				16: r = 32'h00003FFF;
				17: r = 32'h00001FFF;
				18: r = 32'h00000FFF;
				19: r = 32'h000007FF;
				20: r = 32'h000003FF;
				21: r = 32'h000001FF;
				22: r = 32'h000000FF;
				23: r = 32'h0000007F;
				24: r = 32'h0000003F;
				25: r = 32'h0000001F;
				26: r = 32'h0000000F;
				27: r = 32'h00000008;
				28: r = 32'h00000004;
				29: r = 32'h00000002;
				default: r = 32'h00000000;
			endcase
			return r;
		end
	endfunction

	// clip to [-1, 1] in Q2.30
	function automatic logic signed [31:0] sat_one(input logic signed [CW-1:0] v);
		logic signed [31:0] r;
		begin
			if (v > CW'(ONE_Q30))
				r = ONE_Q30;
			else if (v < -CW'(ONE_Q30))
				r = -ONE_Q30;
			else
				r = v[31:0];
			return r;
		end
	endfunction

endpackage

// File: src/aaq_prep.sv
// Entry stage: clamp the angle, double it to a Q.30 half angle and fold into +-pi/2.
module aaq_prep
	import aaq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	output logic               out_valid,
	input  logic               out_ready,
	output cordic_t            out_data
);

	logic signed [31:0]   a_cl;
	logic signed [CW-1:0] z_dbl;
	logic signed [CW-1:0] z_fold;
	logic                 flip;
	logic                 valid_s1;
	cordic_t              data_s1;

	// clamp to +-2*pi, then fold the half angle into the CORDIC range
	always_comb begin
		if (angle > ANGLE_LIMIT)
			a_cl = ANGLE_LIMIT;
		else if (angle < -ANGLE_LIMIT)
			a_cl = -ANGLE_LIMIT;
		else
			a_cl = angle;
		z_dbl = {{(CW-33){a_cl[31]}}, a_cl, 1'b0};
		if (z_dbl > PI_HALF_Q30) begin
			z_fold = z_dbl - PI_Q30;
			flip   = 1'b1;
		end else if (z_dbl < -PI_HALF_Q30) begin
			z_fold = z_dbl + PI_Q30;
			flip   = 1'b1;
		end else begin
			z_fold = z_dbl;
			flip   = 1'b0;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// load a new request when the stage moves on
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.x    <= CORDIC_GAIN_Q30;
			data_s1.y    <= '0;
			data_s1.z    <= z_fold;
			data_s1.flip <= flip;
			data_s1.zero <= (angle == 32'sd0);
			data_s1.ax   <= axis_x;
			data_s1.ay   <= axis_y;
			data_s1.az   <= axis_z;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// File: src/aaq_cordic_stage.sv
// One rotation-mode CORDIC micro-rotation with its own pipeline register.
module aaq_cordic_stage
	import aaq_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  cordic_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output cordic_t out_data
);

	localparam logic signed [CW-1:0] ATAN_I = CW'(signed'({1'b0, atan_q30(IDX)}));

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	cordic_t              nxt;
	logic                 valid_s1;
	cordic_t              data_s1;

	// rotate towards zero residual angle
	always_comb begin
		dx  = in_data.y >>> IDX;
		dy  = in_data.x >>> IDX;
		nxt = in_data;
		if (!in_data.z[CW-1]) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - ATAN_I;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + ATAN_I;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// File: src/aaq_post.sv
// Output stages: unfold and saturate sine/cosine, scale the axis, round and saturate.
module aaq_post
	import aaq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cordic_t            in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z
);

	logic                 rdy1;
	logic                 rdy2;
	logic                 rdy3;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic signed [CW-1:0] c_neg;
	logic signed [CW-1:0] s_neg;
	logic signed [31:0]   c_s1;
	logic signed [31:0]   s_s1;
	logic signed [31:0]   ax_s1;
	logic signed [31:0]   ay_s1;
	logic signed [31:0]   az_s1;
	logic signed [31:0]   w_s2;
	logic signed [63:0]   px_s2;
	logic signed [63:0]   py_s2;
	logic signed [63:0]   pz_s2;
	logic signed [63:0]   rx;
	logic signed [63:0]   ry;
	logic signed [63:0]   rz;
	logic signed [31:0]   w_s3;
	logic signed [31:0]   x_s3;
	logic signed [31:0]   y_s3;
	logic signed [31:0]   z_s3;

	// ready chain: a stage takes a request when empty or when it drains
	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1)
				valid_s1 <= in_valid;
			if (rdy2)
				valid_s2 <= valid_s1;
			if (rdy3)
				valid_s3 <= valid_s2;
		end
	end

	// undo the quadrant fold
	assign c_neg = in_data.flip ? -in_data.x : in_data.x;
	assign s_neg = in_data.flip ? -in_data.y : in_data.y;

	// stage 1: saturate; a zero angle becomes the identity rotation
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			c_s1  <= in_data.zero ? ONE_Q30 : sat_one(c_neg);
			s_s1  <= in_data.zero ? 32'sd0 : sat_one(s_neg);
			ax_s1 <= in_data.ax;
			ay_s1 <= in_data.ay;
			az_s1 <= in_data.az;
		end
	end

	// stage 2: one multiplier per vector component
	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			w_s2  <= c_s1;
			px_s2 <= 64'(s_s1) * 64'(ax_s1);
			py_s2 <= 64'(s_s1) * 64'(ay_s1);
			pz_s2 <= 64'(s_s1) * 64'(az_s1);
		end
	end

	// round half up, drop 30 fraction bits
	assign rx = px_s2 + ROUND_HALF;
	assign ry = py_s2 + ROUND_HALF;
	assign rz = pz_s2 + ROUND_HALF;

	// stage 3: saturate into the output register
	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			w_s3 <= w_s2;
			x_s3 <= sat_one(rx[63:30]);
			y_s3 <= sat_one(ry[63:30]);
			z_s3 <= sat_one(rz[63:30]);
		end
	end

	assign out_valid = valid_s3;
	assign quat_w    = w_s3;
	assign quat_x    = x_s3;
	assign quat_y    = y_s3;
	assign quat_z    = z_s3;

endmodule

// File: src/axis_angle_to_quaternion_core.sv
// Top level of the axis-angle to unit quaternion converter.
// Takes an angle (Q3.28 radians, clamped to +-2*pi) and an axis (Q2.30, used as given)
// and returns w = cos(angle/2), (x, y, z) = sin(angle/2) * axis in Q2.30, saturated
// to +-1. One request is accepted every cycle unless back-pressure has filled the
// pipeline. Each result passes through one register stage to clamp and fold the
// angle, one register stage per CORDIC micro-rotation, then three
// output stages (unfold and saturate, multiply, round and saturate). Every stage
// holds under back-pressure and fills its bubbles, so a stalled output only stops
// the pipeline once every stage in front of it is occupied. A zero angle gives the
// identity quaternion exactly.
module axis_angle_to_quaternion_core
	import aaq_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z
);

	localparam int NSTG = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;

	cordic_t stg_data  [0:NSTG];
	logic    stg_valid [0:NSTG];
	logic    stg_ready [0:NSTG];

	// clamp and fold
	aaq_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.axis_x    (axis_x),
		.axis_y    (axis_y),
		.axis_z    (axis_z),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_data  (stg_data[0])
	);

	// one register stage per micro-rotation
	for (genvar i = 0; i < NSTG; i++) begin : g_rot
		aaq_cordic_stage #(
			.IDX (i)
		) u_rot (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_ready  (stg_ready[i]),
			.in_data   (stg_data[i]),
			.out_valid (stg_valid[i+1]),
			.out_ready (stg_ready[i+1]),
			.out_data  (stg_data[i+1])
		);
	end

	// scale, round and saturate
	aaq_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[NSTG]),
		.in_ready  (stg_ready[NSTG]),
		.in_data   (stg_data[NSTG]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z)
	);

endmodule

// File: src/aaq_checker.sv
// Port-level checks for the converter, bound to the top level.
module aaq_checker #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] quat_w,
	input logic [31:0] quat_x
);

	localparam int DEPTH = CORDIC_ITERATIONS + 4;
	localparam int FW    = $clog2(DEPTH + 2) + 1;

	logic [FW-1:0] in_flight_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// count requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_flight_q <= '0;
		else if (in_acc && !out_acc)
			in_flight_q <= in_flight_q + 1'b1;
		else if (out_acc && !in_acc)
			in_flight_q <= in_flight_q - 1'b1;
	end

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its w and x values
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(quat_w) && $stable(quat_x))
		else $error("result changed while stalled");

	// no result without a request behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_flight_q != '0)
		else $error("result without a request");

	// never more in flight than the pipeline holds
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= FW'(DEPTH))
		else $error("more requests in flight than stages");

	// an empty output register leaves the input open
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind axis_angle_to_quaternion_core aaq_checker #(
	.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
) u_aaq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quat_w    (quat_w),
	.quat_x    (quat_x)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the axis-angle to quaternion converter core.
module tb;

	localparam int     CORDIC_ITER  = 24;
	localparam int     ATAN_LEN     = 30;
	localparam int     RUN_LIMIT    = 200000;
	localparam int     PRINT_LIMIT  = 50;
	localparam longint ANGLE_MAX    = 64'sd1686629713;
	localparam longint PI_Q30       = 64'sd3373259426;
	localparam longint HALF_PI_Q30  = 64'sd1686629713;
	localparam longint GAIN_Q30     = 64'sd652032874;
	localparam longint UNIT_Q30     = 64'sd1073741824;
	localparam longint ROUND_Q30    = 64'sd536870912;
	// half-angle fold boundary expressed as a Q3.28 angle
	localparam int     FOLD_EDGE    = 843314856;

	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} quat_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic signed [31:0] angle     = '0;
	logic signed [31:0] axis_x    = '0;
	logic signed [31:0] axis_y    = '0;
	logic signed [31:0] axis_z    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] quat_w;
	logic signed [31:0] quat_x;
	logic signed [31:0] quat_y;
	logic signed [31:0] quat_z;

	// atan(2^-i) in Q.30, truncated
	longint atan_q30 [0:ATAN_LEN-1] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	quat_t quat_expected [$];
	int    mismatch_count = 0;
	int    result_count   = 0;
	int    cycle_count    = 0;
	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;
	int    hold_len       = 0;
	logic  rx_hold        = 1'b0;

	axis_angle_to_quaternion_core #(
		.CORDIC_ITERATIONS(CORDIC_ITER)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.angle(angle),
		.axis_x(axis_x),
		.axis_y(axis_y),
		.axis_z(axis_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quat_w(quat_w),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// clip to [-1, 1] in Q2.30
	function automatic longint clip_unit(input longint v);
		if (v > UNIT_Q30)
			return UNIT_Q30;
		if (v < -UNIT_Q30)
			return -UNIT_Q30;
		return v;
	endfunction

	// sine times one axis component, rounded half up
	function automatic logic signed [31:0] scale_axis(input longint s,
			input logic signed [31:0] comp);
		longint p;
		p = clip_unit(((s * longint'(comp)) + ROUND_Q30) >>> 30);
		return p[31:0];
	endfunction

	// quaternion for one rotation: fold the half angle, rotate, scale the axis
	function automatic quat_t quat_from_axis_angle(input logic signed [31:0] ang,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az);
		longint a, z, cx, cy, dx, dy, c, s;
		bit     flip;
		quat_t  q;
		a = longint'(ang);
		if (a == 0) begin
			q.w = UNIT_Q30[31:0];
			q.x = '0;
			q.y = '0;
			q.z = '0;
			return q;
		end
		if (a > ANGLE_MAX)
			a = ANGLE_MAX;
		if (a < -ANGLE_MAX)
			a = -ANGLE_MAX;
		z    = a * 2;
		flip = 1'b0;
		if (z > HALF_PI_Q30) begin
			z    = z - PI_Q30;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z    = z + PI_Q30;
			flip = 1'b1;
		end
		cx = GAIN_Q30;
		cy = 0;
		for (int i = 0; i < CORDIC_ITER && i < ATAN_LEN; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				z  = z - atan_q30[i];
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				z  = z + atan_q30[i];
			end
		end
		c   = clip_unit(flip ? -cx : cx);
		s   = clip_unit(flip ? -cy : cy);
		q.w = c[31:0];
		q.x = scale_axis(s, ax);
		q.y = scale_axis(s, ay);
		q.z = scale_axis(s, az);
		return q;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("tb: mismatch on result %0d: %s got %0d expected %0d",
				result_count, what, $signed(got), $signed(want));
		mismatch_count++;
	endtask

	// offer one request, hold it until accepted, then record its quaternion
	task automatic send_request(input logic signed [31:0] a,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		angle    <= a;
		axis_x   <= ax;
		axis_y   <= ay;
		axis_z   <= az;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		quat_expected.push_back(quat_from_axis_angle(a, ax, ay, az));
	endtask

	// drop valid and wait until every outstanding result is back
	task automatic wait_drained;
		in_valid <= 1'b0;
		while (quat_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_batch(input int count);
		logic signed [31:0] a, ax, ay, az;
		int                 pick;
		repeat (count) begin
			pick = $urandom_range(99);
			ax   = 32'($urandom_range(32'h80000000)) - 32'd1073741824;
			ay   = 32'($urandom_range(32'h80000000)) - 32'd1073741824;
			az   = 32'($urandom_range(32'h80000000)) - 32'd1073741824;
			if (pick < 68) begin
				a = 32'($urandom_range(32'd3373259426)) - 32'd1686629713;
			end else if (pick < 82) begin
				// full-range noise, clamped angle and saturating axis
				a  = $urandom;
				ax = $urandom;
				ay = $urandom;
				az = $urandom;
			end else if (pick < 91) begin
				a = 32'($urandom_range(4095)) - 32'd2048;
			end else if (pick < 95) begin
				a = '0;
			end else begin
				a = FOLD_EDGE + 32'($urandom_range(64)) - 32'd32;
				if ($urandom_range(1))
					a = -a;
			end
			send_request(a, ax, ay, az);
		end
	endtask

	// extremes, zero angle, clamping, fold boundary and saturating axes
	task automatic test_directed;
		send_request(32'sd0, 32'sd1073741824, 32'sd0, 32'sd0);
		send_request(32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd5);
		send_request(32'sd1, 32'sd1073741824, 32'sd0, 32'sd0);
		send_request(-32'sd1, 32'sd0, 32'sd1073741824, 32'sd0);
		send_request(32'sd268435456, 32'sd0, 32'sd0, 32'sd1073741824);
		send_request(-32'sd268435456, 32'sd0, 32'sd0, -32'sd1073741824);
		send_request(32'sd1686629713, 32'sd1073741824, 32'sd0, 32'sd0);
		send_request(-32'sd1686629713, 32'sd0, -32'sd1073741824, 32'sd0);
		send_request(32'sd1686629714, 32'sd1073741824, 32'sd1073741824, 32'sd0);
		send_request(-32'sd1686629714, 32'sd0, 32'sd1073741824, 32'sd1073741824);
		send_request(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_request(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_request(FOLD_EDGE, 32'sd1073741824, -32'sd1073741824, 32'sd0);
		send_request(FOLD_EDGE + 1, 32'sd1073741824, -32'sd1073741824, 32'sd0);
		send_request(-FOLD_EDGE, -32'sd1073741824, 32'sd0, 32'sd1073741824);
		send_request(-FOLD_EDGE - 1, -32'sd1073741824, 32'sd0, 32'sd1073741824);
		send_request(32'sd843314855, 32'sd759250125, 32'sd759250125, 32'sd0);
		send_request(32'sd421657428, 32'sd1073741824, 32'sd1073741824, 32'sd1073741824);
		send_request(-32'sd1264972284, -32'sd1073741824, -32'sd1073741824,
			-32'sd1073741824);
		send_request(32'sd1000000000, 32'sh7FFFFFFF, -32'sd1, 32'sd1);
		send_request(-32'sd1000000000, 32'sh80000000, 32'sd1, -32'sd1);
		wait_drained;
	endtask

	task automatic test_stream_no_idle;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_random_batch(330);
		wait_drained;
	endtask

	task automatic test_sender_gaps;
		send_idle_pct  = 50;
		recv_stall_pct = 0;
		send_random_batch(330);
		wait_drained;
	endtask

	task automatic test_receiver_stalls;
		send_idle_pct  = 0;
		recv_stall_pct = 50;
		send_random_batch(330);
		wait_drained;
	endtask

	task automatic test_light_gaps_both;
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		send_random_batch(330);
		wait_drained;
	endtask

	// hold the output off long enough that the pipeline fills and input stalls
	task automatic test_full_pipeline;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_len      <= 300;
		send_random_batch(100);
		wait_drained;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed;
		test_stream_no_idle;
		test_sender_gaps;
		test_receiver_stalls;
		test_light_gaps_both;
		test_full_pipeline;
		repeat (CORDIC_ITER + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// count out a long receiver hold-off once requested
	initial begin : rx_hold_timer
		int n;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				n = hold_len;
				hold_len <= 0;
				rx_hold  <= 1'b1;
				repeat (n) @(posedge clk);
				rx_hold  <= 1'b0;
			end
		end
	end

	// check each accepted result against the oldest expectation, then pick ready
	always @(posedge clk) begin : rx_check
		quat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (quat_expected.size() == 0) begin
					report_mismatch("unexpected quat_w", quat_w, 32'd0);
				end else begin
					want = quat_expected.pop_front();
					if (quat_w !== want.w)
						report_mismatch("quat_w", quat_w, want.w);
					if (quat_x !== want.x)
						report_mismatch("quat_x", quat_x, want.x);
					if (quat_y !== want.y)
						report_mismatch("quat_y", quat_y, want.y);
					if (quat_z !== want.z)
						report_mismatch("quat_z", quat_z, want.z);
				end
				result_count++;
			end
			out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: done, errors");
			$finish;
		end
	end

endmodule
